>>> src/bde_pkg.sv
// ----------------------------------------------------------------------------
// bde_pkg: shared types and constants for the bounded deque engine
// Operation and status codes, sequencer states and the result beat bundle.
// ----------------------------------------------------------------------------
package bde_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int ITEM_W       = 32;

    localparam logic signed [ITEM_W-1:0] EMPTY_ITEM = -32'sd1;

    typedef enum logic [2:0] {
        K_PUSH_BACK  = 3'd0,
        K_PUSH_FRONT = 3'd1,
        K_POP_BACK   = 3'd2,
        K_POP_FRONT  = 3'd3,
        K_INSERT     = 3'd4,
        K_ERASE      = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_BEYOND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FINISH,
        S_READ_FRONT,
        S_READ_BACK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic    done;
        t_status status;
    } t_result;

endpackage

>>> src/bounded_deque_engine.sv
// ----------------------------------------------------------------------------
// bounded_deque_engine: double-ended queue in a ring store
// Top level: input handshake, sequencer and result register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall carry one operation per beat (kind, item,
//   position). Output channel: o_valid / i_stall carry one result per beat
//   (front, back, count, empty flag, status). Every operation gives exactly
//   one result beat, in order.
//   Sequence: after the accepting edge the block decides, reads the front,
//   reads the back and loads the result register; the back read is skipped
//   when the queue is empty after the operation. Insert and erase move items
//   in between, one read then one write per moved item (count - position for
//   insert, position for erase), then do the final write or head advance,
//   because the ring store's read and write share one slot address.
//   o_stall is high while an operation is in flight, so the block takes a
//   new beat only after the previous one has reached the result register.
//   Stalls: the result register holds a beat while i_stall is high; the block
//   still accepts and runs the next operation and waits at its end until the
//   register frees.
//   Reset: head and count clear to zero, so the queue reads empty; store
//   contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module bounded_deque_engine #(
    parameter int CAPACITY = bde_pkg::CAPACITY_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [2:0]                         i_kind,
    input  logic signed [bde_pkg::ITEM_W-1:0]  i_item,
    input  logic [$clog2(CAPACITY+1)-1:0]      i_position,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [bde_pkg::ITEM_W-1:0]  o_front_item,
    output logic signed [bde_pkg::ITEM_W-1:0]  o_back_item,
    output logic [$clog2(CAPACITY+1)-1:0]      o_item_count,
    output logic                               o_is_empty,
    output logic [1:0]                         o_status
);
    import bde_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    t_result                   res;
    logic                      busy;
    logic                      out_free;
    logic signed [ITEM_W-1:0]  seq_front;
    logic signed [ITEM_W-1:0]  seq_back;
    logic [CW-1:0]             seq_count;

    logic                      r_o_valid, n_o_valid;
    logic signed [ITEM_W-1:0]  r_front, n_front;
    logic signed [ITEM_W-1:0]  r_back, n_back;
    logic [CW-1:0]             r_count, n_count;
    t_status                   r_status, n_status;

    // result register frees when empty or when its beat leaves this cycle
    assign out_free = !r_o_valid || !i_stall;

    bde_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_busy     (busy),
        .i_kind     (i_kind),
        .i_item     (i_item),
        .i_pos      (i_position),
        .i_out_free (out_free),
        .o_res      (res),
        .o_front    (seq_front),
        .o_back     (seq_back),
        .o_count    (seq_count)
    );

    // load a finished result, otherwise drop the beat once taken
    always_comb begin
        n_o_valid = r_o_valid;
        n_front   = r_front;
        n_back    = r_back;
        n_count   = r_count;
        n_status  = r_status;
        if (res.done) begin
            n_o_valid = 1'b1;
            n_front   = seq_front;
            n_back    = seq_back;
            n_count   = seq_count;
            n_status  = res.status;
        end else if (!i_stall) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= n_o_valid;
        end
        r_front  <= n_front;
        r_back   <= n_back;
        r_count  <= n_count;
        r_status <= n_status;
    end

    assign o_stall      = busy;
    assign o_valid      = r_o_valid;
    assign o_front_item = r_front;
    assign o_back_item  = r_back;
    assign o_item_count = r_count;
    assign o_is_empty   = (r_count == '0);
    assign o_status     = r_status;

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.done |-> out_free)
        else $error("result loaded over a held beat");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("not busy after accepting an operation");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_front_item)
            && $stable(o_back_item) && $stable(o_item_count) && $stable(o_status)))
        else $error("stalled result beat changed");

endmodule

>>> src/bde_slot.sv
// ----------------------------------------------------------------------------
// bde_slot: ring address unit
// Maps an offset from the head to a ring slot with one add and one wrap.
// ----------------------------------------------------------------------------
module bde_slot #(
    parameter int CAPACITY = 256
) (
    input  logic [$clog2(CAPACITY)-1:0]   i_base,
    input  logic [$clog2(CAPACITY+1)-1:0] i_offset,
    output logic [$clog2(CAPACITY)-1:0]   o_slot
);
    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;

    logic [SW-1:0] sum;
    logic [SW-1:0] wrapped;

    // base < CAPACITY and offset <= CAPACITY, so one subtract is enough
    assign sum     = SW'(i_base) + SW'(i_offset);
    assign wrapped = (sum >= SW'(CAPACITY)) ? (sum - SW'(CAPACITY)) : sum;
    assign o_slot  = wrapped[IW-1:0];

endmodule

>>> src/bde_store.sv
// ----------------------------------------------------------------------------
// bde_store: ring storage
// One write port and one registered read port; read data holds when idle.
// ----------------------------------------------------------------------------
module bde_store #(
    parameter int CAPACITY = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rd_en,
    input  logic [$clog2(CAPACITY)-1:0] i_rd_addr,
    input  logic                        i_wr_en,
    input  logic [$clog2(CAPACITY)-1:0] i_wr_addr,
    input  logic [bde_pkg::ITEM_W-1:0]  i_wr_data,
    output logic [bde_pkg::ITEM_W-1:0]  o_rd_data
);
    import bde_pkg::*;

    logic [ITEM_W-1:0] r_mem [CAPACITY];
    logic [ITEM_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/bde_ctrl.sv
// ----------------------------------------------------------------------------
// bde_ctrl: deque sequencer
// Runs one operation at a time over the ring store through the shared slot
// unit: decide, shift one item per read and write, finish, then read front and back.
// ----------------------------------------------------------------------------
module bde_ctrl #(
    parameter int CAPACITY = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_busy,
    input  logic [2:0]                          i_kind,
    input  logic signed [bde_pkg::ITEM_W-1:0]   i_item,
    input  logic [$clog2(CAPACITY+1)-1:0]       i_pos,
    input  logic                                i_out_free,
    output bde_pkg::t_result                    o_res,
    output logic signed [bde_pkg::ITEM_W-1:0]   o_front,
    output logic signed [bde_pkg::ITEM_W-1:0]   o_back,
    output logic [$clog2(CAPACITY+1)-1:0]       o_count
);
    import bde_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    t_state                    r_state, n_state;
    t_kind                     r_kind, n_kind;
    logic signed [ITEM_W-1:0]  r_item, n_item;
    logic [CW-1:0]             r_pos, n_pos;
    logic [IW-1:0]             r_head, n_head;
    logic [CW-1:0]             r_count, n_count;
    logic [CW-1:0]             r_idx, n_idx;
    logic [CW-1:0]             r_low, n_low;
    t_status                   r_status, n_status;
    logic signed [ITEM_W-1:0]  r_front, n_front;

    t_status                   op_status;
    logic [CW-1:0]             slot_off;
    logic [IW-1:0]             slot_addr;
    logic                      mem_rd_en;
    logic                      mem_wr_en;
    logic [ITEM_W-1:0]         mem_wr_data;
    logic [ITEM_W-1:0]         mem_rd_data;

    bde_slot #(.CAPACITY(CAPACITY)) u_slot (
        .i_base   (r_head),
        .i_offset (slot_off),
        .o_slot   (slot_addr)
    );

    bde_store #(.CAPACITY(CAPACITY)) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (slot_addr),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (slot_addr),
        .i_wr_data (mem_wr_data),
        .o_rd_data (mem_rd_data)
    );

    // status of the captured operation against the current fill
    always_comb begin
        op_status = ST_OK;
        case (r_kind)
            K_PUSH_BACK, K_PUSH_FRONT: begin
                op_status = (r_count >= CW'(CAPACITY)) ? ST_FULL : ST_OK;
            end
            K_POP_BACK, K_POP_FRONT: begin
                op_status = (r_count == '0) ? ST_EMPTY : ST_OK;
            end
            K_INSERT: begin
                priority if (r_pos > r_count)              op_status = ST_BEYOND;
                else if (r_count >= CW'(CAPACITY))         op_status = ST_FULL;
                else                                       op_status = ST_OK;
            end
            K_ERASE: begin
                priority if (r_count == '0)                op_status = ST_EMPTY;
                else if (r_pos > r_count)                  op_status = ST_BEYOND;
                else if (r_pos == r_count)                 op_status = ST_EMPTY;
                else                                       op_status = ST_OK;
            end
            default: op_status = ST_OK;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (op_status == ST_OK && r_kind == K_INSERT) begin
                    n_state = (r_count != r_pos) ? S_SHIFT_RD : S_FINISH;
                end else if (op_status == ST_OK && r_kind == K_ERASE) begin
                    n_state = (r_pos != '0) ? S_SHIFT_RD : S_FINISH;
                end else begin
                    n_state = S_READ_FRONT;
                end
            end
            S_SHIFT_RD: n_state = S_SHIFT_WR;
            S_SHIFT_WR: begin
                n_state = ((r_idx - CW'(1)) == r_low) ? S_FINISH : S_SHIFT_RD;
            end
            S_FINISH:     n_state = S_READ_FRONT;
            S_READ_FRONT: n_state = (r_count == '0) ? S_DONE : S_READ_BACK;
            S_READ_BACK:  n_state = S_DONE;
            S_DONE: begin
                if (i_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and store control
    always_comb begin
        n_kind      = r_kind;
        n_item      = r_item;
        n_pos       = r_pos;
        n_head      = r_head;
        n_count     = r_count;
        n_idx       = r_idx;
        n_low       = r_low;
        n_status    = r_status;
        n_front     = r_front;
        slot_off    = '0;
        mem_rd_en   = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_data = r_item;
        o_res.done   = 1'b0;
        o_res.status = r_status;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_kind = t_kind'(i_kind);
                    n_item = i_item;
                    n_pos  = i_pos;
                end
            end
            S_EXEC: begin
                n_status = op_status;
                if (op_status == ST_OK) begin
                    case (r_kind)
                        K_PUSH_BACK: begin
                            slot_off  = r_count;
                            mem_wr_en = 1'b1;
                            n_count   = r_count + CW'(1);
                        end
                        K_PUSH_FRONT: begin
                            slot_off  = CW'(CAPACITY - 1);
                            mem_wr_en = 1'b1;
                            n_head    = slot_addr;
                            n_count   = r_count + CW'(1);
                        end
                        K_POP_BACK: begin
                            n_count = r_count - CW'(1);
                        end
                        K_POP_FRONT: begin
                            slot_off = CW'(1);
                            n_head   = slot_addr;
                            n_count  = r_count - CW'(1);
                        end
                        K_INSERT: begin
                            n_idx = r_count;
                            n_low = r_pos;
                        end
                        K_ERASE: begin
                            n_idx = r_pos;
                            n_low = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_SHIFT_RD: begin
                slot_off  = r_idx - CW'(1);
                mem_rd_en = 1'b1;
            end
            S_SHIFT_WR: begin
                slot_off    = r_idx;
                mem_wr_en   = 1'b1;
                mem_wr_data = mem_rd_data;
                n_idx       = r_idx - CW'(1);
            end
            S_FINISH: begin
                if (r_kind == K_INSERT) begin
                    slot_off  = r_pos;
                    mem_wr_en = 1'b1;
                    n_count   = r_count + CW'(1);
                end else begin
                    // erase: drop the duplicated front
                    slot_off = CW'(1);
                    n_head   = slot_addr;
                    n_count  = r_count - CW'(1);
                end
            end
            S_READ_FRONT: begin
                mem_rd_en = (r_count != '0);
                if (r_count == '0) n_front = EMPTY_ITEM;
            end
            S_READ_BACK: begin
                n_front   = mem_rd_data;
                slot_off  = r_count - CW'(1);
                mem_rd_en = 1'b1;
            end
            S_DONE: begin
                o_res.done = i_out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
        end
        r_kind   <= n_kind;
        r_item   <= n_item;
        r_pos    <= n_pos;
        r_idx    <= n_idx;
        r_low    <= n_low;
        r_status <= n_status;
        r_front  <= n_front;
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_front = r_front;
    assign o_back  = (r_count == '0) ? EMPTY_ITEM : $signed(mem_rd_data);
    assign o_count = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("fill count above capacity");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_rd_en && mem_wr_en))
        else $error("store read and write in one cycle");

    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT_WR) |-> (r_idx > r_low))
        else $error("shift index at or below its floor");

endmodule
